// File: rtl/mma_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the matrix multiply-add unit.
// No dependencies; imported by every module of the block except mma_ram.
package mma_pkg;

    // largest supported matrix side and derived store geometry
    localparam int MAX_SIZE = 16;
    localparam int IDX_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = 1 << ADDR_W;

    // fixed field widths
    localparam int DATA_W   = 32;
    localparam int SIZE_W   = 5;
    localparam int ROW_W    = 4;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    // register index decoded from paddr[2]
    localparam logic REG_MATRIX_SIZE = 1'b0;

    // load order of the three matrices
    typedef enum logic [1:0] {
        PH_A = 2'd0,
        PH_B = 2'd1,
        PH_C = 2'd2
    } phase_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic issue;
    } mac_ctrl_t;

endpackage

// File: rtl/mma_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/mma_mac.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: product register, then accumulator.
// Depends on mma_pkg; fed by the two matrix stores.
module mma_mac (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mma_pkg::mac_ctrl_t       mac_ctrl,
    input  logic [mma_pkg::DATA_W-1:0] a_data,
    input  logic [mma_pkg::DATA_W-1:0] b_data,
    output logic [mma_pkg::DATA_W-1:0] acc,
    output logic                     busy
);
    import mma_pkg::*;

    logic              rd_valid_reg;
    logic              prod_valid_reg;
    logic [DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0] acc_reg;

    // valid tracking for the store read and product stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg   <= mac_ctrl.issue;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    // low 32 bits of the product, same for signed and unsigned
    always_ff @(posedge clk)
    begin
        prod_reg <= a_data * b_data;
    end

    // accumulator, wraps modulo 2^32
    always_ff @(posedge clk)
    begin
        if (mac_ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc  = acc_reg;
    assign busy = rd_valid_reg | prod_valid_reg;

endmodule

// File: rtl/mma_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: load order tracking, store addressing, dot product issue
// and the output register. Depends on mma_pkg.
module mma_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr,
    input  logic [mma_pkg::SIZE_W-1:0]  matrix_size,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mma_pkg::DATA_W-1:0]  element_value,
    input  logic                        start_of_set,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mma_pkg::DATA_W-1:0]  result_value,
    output logic [mma_pkg::ROW_W-1:0]   result_row,
    output logic [mma_pkg::ROW_W-1:0]   result_col,
    output logic                        last_of_set,
    output logic                        a_wr_en,
    output logic                        b_wr_en,
    output logic [mma_pkg::ADDR_W-1:0]  wr_addr,
    output logic [mma_pkg::ADDR_W-1:0]  a_rd_addr,
    output logic [mma_pkg::ADDR_W-1:0]  b_rd_addr,
    output mma_pkg::mac_ctrl_t          mac_ctrl,
    input  logic                        mac_busy,
    input  logic [mma_pkg::DATA_W-1:0]  acc
);
    import mma_pkg::*;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  col_reg, col_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  nm1;
    phase_t            cur_phase;
    logic [IDX_W-1:0]  cur_row;
    logic [IDX_W-1:0]  cur_col;
    logic              accept;
    logic              c_accept;
    logic              load_out;

    logic [DATA_W-1:0] c_value_reg;
    logic [IDX_W-1:0]  res_row_reg;
    logic [IDX_W-1:0]  res_col_reg;
    logic              res_last_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic              out_last_reg;

    // side length minus one, with out-of-range sizes clamped
    always_comb
    begin
        if (matrix_size == '0)
        begin
            nm1 = '0;
        end
        else if (32'(matrix_size) > MAX_SIZE)
        begin
            nm1 = IDX_W'(MAX_SIZE - 1);
        end
        else
        begin
            nm1 = IDX_W'(matrix_size - SIZE_W'(1));
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // start flag restarts at the first element of A
    assign cur_phase = start_of_set ? PH_A : phase_reg;
    assign cur_row   = start_of_set ? '0 : row_reg;
    assign cur_col   = start_of_set ? '0 : col_reg;
    assign c_accept  = accept && (cur_phase == PH_C);

    // store writes for A and B beats
    assign wr_addr = {cur_row, cur_col};
    assign a_wr_en = accept && (cur_phase == PH_A);
    assign b_wr_en = accept && (cur_phase == PH_B);

    // dot product read addresses: row of A, column of B
    assign a_rd_addr = {res_row_reg, k_reg};
    assign b_rd_addr = {k_reg, res_col_reg};

    assign mac_ctrl.clear = c_accept;
    assign mac_ctrl.issue = (state_reg == ST_ISSUE);

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // load position advance
    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        if (cfg_wr)
        begin
            phase_next = PH_A;
            row_next   = '0;
            col_next   = '0;
        end
        else if (accept)
        begin
            phase_next = cur_phase;
            row_next   = cur_row;
            col_next   = cur_col + IDX_W'(1);
            if (cur_col == nm1)
            begin
                col_next = '0;
                row_next = cur_row + IDX_W'(1);
                if (cur_row == nm1)
                begin
                    row_next = '0;
                    unique case (cur_phase)
                        PH_A:    phase_next = PH_B;
                        PH_B:    phase_next = PH_C;
                        default: phase_next = PH_A;
                    endcase
                end
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                k_next = '0;
                if (c_accept)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                k_next = k_reg + IDX_W'(1);
                if (k_reg == nm1)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_A;
            row_reg       <= '0;
            col_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            k_reg     <= k_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // C beat capture
    always_ff @(posedge clk)
    begin
        if (c_accept)
        begin
            c_value_reg  <= element_value;
            res_row_reg  <= cur_row;
            res_col_reg  <= cur_col;
            res_last_reg <= (cur_row == nm1) && (cur_col == nm1);
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_value_reg <= acc + c_value_reg;
            out_row_reg   <= res_row_reg;
            out_col_reg   <= res_col_reg;
            out_last_reg  <= res_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign result_row   = ROW_W'(out_row_reg);
    assign result_col   = ROW_W'(out_col_reg);
    assign last_of_set  = out_last_reg;

endmodule

// File: rtl/matrix_multiply_add_unit.sv
`timescale 1ns / 1ps
// Top level of the matrix multiply-add unit: config register, stores,
// sequencer and MAC. Depends on mma_pkg, mma_ram, mma_mac, mma_ctrl.
//
// Usage: D = A*B + C for N x N signed 32-bit matrices, N set by the
// matrix_size register (APB, byte address 0; 0 acts as 1, above 16 as 16).
// Input beats carry one element each, row-major: all of A, then B, then C.
// start_of_set marks A[0][0] and restarts the load order; a config write
// restarts it as well. A and B beats are written to the stores and produce
// no result; each C beat produces one result beat D[i][j] with its row and
// column, and last_of_set on D[N-1][N-1].
// Flow control: in_ready is high only while the sequencer is idle, and an
// A or B beat does not lower it. A C beat holds in_ready low while N store
// reads go through the one shared multiply-accumulate unit, its pipeline
// drains and the output register loads.
// The output register holds a result while the receiver stalls; the block
// keeps accepting A and B beats meanwhile, and a following C beat waits for
// the register to free before it finishes. Reset empties the output, sets
// matrix_size to 16 and the load order to A[0][0]; store contents stay
// undefined until written.
module matrix_multiply_add_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mma_pkg::PADDR_W-1:0]   paddr,
    input  logic [mma_pkg::PDATA_W-1:0]   pwdata,
    output logic [mma_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [mma_pkg::DATA_W-1:0] element_value,
    input  logic                          start_of_set,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [mma_pkg::DATA_W-1:0] result_value,
    output logic [mma_pkg::ROW_W-1:0]     result_row,
    output logic [mma_pkg::ROW_W-1:0]     result_col,
    output logic                          last_of_set
);
    import mma_pkg::*;

    logic [SIZE_W-1:0] size_reg;
    logic              cfg_wr;
    logic              a_wr_en;
    logic              b_wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] a_rd_addr;
    logic [ADDR_W-1:0] b_rd_addr;
    logic [DATA_W-1:0] a_data;
    logic [DATA_W-1:0] b_data;
    logic [DATA_W-1:0] acc;
    logic [DATA_W-1:0] res_value;
    logic              mac_busy;
    mac_ctrl_t         mac_ctrl;

    // config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            REG_MATRIX_SIZE: prdata = PDATA_W'(size_reg);
            default:         prdata = '0;
        endcase
    end

    // matrix stores
    mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_ram (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (wr_addr),
        .wr_data (element_value),
        .rd_addr (a_rd_addr),
        .rd_data (a_data)
    );

    mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b_ram (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (wr_addr),
        .wr_data (element_value),
        .rd_addr (b_rd_addr),
        .rd_data (b_data)
    );

    // shared multiply-accumulate unit
    mma_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .mac_ctrl (mac_ctrl),
        .a_data   (a_data),
        .b_data   (b_data),
        .acc      (acc),
        .busy     (mac_busy)
    );

    // sequencer and output register
    mma_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr        (cfg_wr),
        .matrix_size   (size_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .element_value (element_value),
        .start_of_set  (start_of_set),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_value  (res_value),
        .result_row    (result_row),
        .result_col    (result_col),
        .last_of_set   (last_of_set),
        .a_wr_en       (a_wr_en),
        .b_wr_en       (b_wr_en),
        .wr_addr       (wr_addr),
        .a_rd_addr     (a_rd_addr),
        .b_rd_addr     (b_rd_addr),
        .mac_ctrl      (mac_ctrl),
        .mac_busy      (mac_busy),
        .acc           (acc)
    );

    assign result_value = res_value;

endmodule

// File: rtl/mma_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the matrix multiply-add unit, bound to the top.
// Depends on mma_pkg and matrix_multiply_add_unit.
module mma_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [mma_pkg::PADDR_W-1:0]   paddr,
    input logic [mma_pkg::PDATA_W-1:0]   pwdata,
    input logic [mma_pkg::PDATA_W-1:0]   prdata,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mma_pkg::DATA_W-1:0]    result_value,
    input logic [mma_pkg::ROW_W-1:0]     result_row,
    input logic [mma_pkg::ROW_W-1:0]     result_col,
    input logic                          last_of_set
);
    import mma_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value)
            && $stable(result_row) && $stable(result_col))
        else $error("result beat changed under stall");

    // the final element sits on the diagonal
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_set |-> result_row == result_col)
        else $error("last_of_set off the diagonal");

    // a new result only appears while the input side is held off
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while input was open");

    // size register reads back what was written
    a_size_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == REG_MATRIX_SIZE
            |=> paddr[2] != REG_MATRIX_SIZE
                || prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0]))
        else $error("matrix_size readback mismatch");

endmodule

bind matrix_multiply_add_unit mma_checker u_mma_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .result_row   (result_row),
    .result_col   (result_col),
    .last_of_set  (last_of_set)
);
